FILE: design/wpm_pkg.sv
`timescale 1ns / 1ps

package wpm_pkg;

  localparam int NUM_CHANNELS  = 2;
  localparam int HISTORY_SLOTS = 8;
  localparam int SAMPLE_BITS   = 16;

  localparam int RING_SIZE = HISTORY_SLOTS * NUM_CHANNELS;
  localparam int ADDR_W    = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SLOT_W    = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
  localparam int SCNT_W    = $clog2(HISTORY_SLOTS + 1);
  localparam int MAG_W     = SAMPLE_BITS - 1;

  localparam int FPC_W      = 13;
  localparam int FRAME_W    = 12;
  localparam int CHAN_OUT_W = 3;
  localparam int LEVEL_W    = 15;

  localparam logic [FPC_W-1:0] FPC_RESET = FPC_W'(512);
  localparam logic [FPC_W-1:0] FPC_MAX   = FPC_W'(4096);

  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RMW   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  function automatic addr_t ring_addr(input logic [SLOT_W-1:0] slot,
                                      input logic [CH_W-1:0] ch);
    ring_addr = ADDR_W'(int'(slot) * NUM_CHANNELS + int'(ch));
  endfunction

  // |sample|, most negative value saturates to the largest positive one
  function automatic mag_t sample_mag(input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] a;
    a = s[SAMPLE_BITS-1] ? (~s + SAMPLE_BITS'(1)) : s;
    sample_mag = a[SAMPLE_BITS-1] ? {MAG_W{1'b1}} : a[MAG_W-1:0];
  endfunction

endpackage

FILE: design/windowed_peak_level_meter_core.sv
`timescale 1ns / 1ps

// Windowed peak level meter.
// Input channel: one signed sample per transaction (in_valid / in_stall),
// channels interleaved 0..NUM_CHANNELS-1. Each sample updates the running
// peak of its channel in the current ring slot (slot restarted on the first
// frame of a chunk). On each sample of the last frame of a chunk the block
// scans that channel's entries over all history slots and sends one result
// (out_channel, out_level, out_last) on the output channel; out_last marks
// the final channel. The slot pointer advances after the chunk.
// Each sample takes a memory read, then a write back (states IDLE, then RMW),
// as the ring memory read is registered; no new sample is taken before the
// write back. A sample that ends a chunk then steps through SCAN, one ring
// read per history slot, and EMIT, which loads the output register once free.
// Reset: synchronous, active low. Afterwards the ring is zeroed by a clearing
// pass over all RING_SIZE entries with in_stall high; cfg writes are taken anytime.
// The result sits in an output register; while out_stall is high samples are
// still accepted, and the block stalls its input once its next result is due.
module windowed_peak_level_meter_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [wpm_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [wpm_pkg::CHAN_OUT_W-1:0]         out_channel,
  output logic [wpm_pkg::LEVEL_W-1:0]            out_level,
  output logic                                   out_last,
  input  logic                                   cfg_wr_en,
  input  logic [wpm_pkg::FPC_W-1:0]              cfg_wr_data
);
  import wpm_pkg::*;

  state_t state_r, state_nxt;

  mag_t  ring_mem [RING_SIZE];
  mag_t  rd_data_r;
  logic  mem_rd_en;
  addr_t mem_rd_addr;
  logic  mem_we;
  addr_t mem_wr_addr;
  mag_t  mem_wr_data;

  logic [FPC_W-1:0]   fpc_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [CH_W-1:0]    chpos_r;
  logic [FRAME_W-1:0] frame_r;
  addr_t              clr_r;
  logic [SCNT_W-1:0]  scan_r;

  mag_t               mag_r;
  logic [CH_W-1:0]    ch_r;
  addr_t              idx_r;
  logic               end_r;
  logic               first_r;
  mag_t               best_r;

  logic                  out_valid_r;
  logic [CHAN_OUT_W-1:0] out_channel_r;
  logic [LEVEL_W-1:0]    out_level_r;
  logic                  out_last_r;

  logic               accept;
  logic [FPC_W-1:0]   eff_len;
  logic               chunk_end;
  mag_t               new_val;
  mag_t               best_nxt;
  logic               ch_last;
  logic               out_free;

  assign in_stall    = (state_r != ST_IDLE);
  assign accept      = in_valid && (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_level   = out_level_r;
  assign out_last    = out_last_r;
  assign out_free    = !out_valid_r || !out_stall;

  always_comb begin
    if (fpc_r == '0) begin
      eff_len = FPC_W'(1);
    end else if (fpc_r > FPC_MAX) begin
      eff_len = FPC_MAX;
    end else begin
      eff_len = fpc_r;
    end
  end

  assign chunk_end = ({1'b0, frame_r} + FPC_W'(1)) >= eff_len;
  assign ch_last   = (chpos_r == CH_W'(NUM_CHANNELS - 1));
  assign new_val   = (first_r || (mag_r > rd_data_r)) ? mag_r : rd_data_r;
  assign best_nxt  = (rd_data_r > best_r) ? rd_data_r : best_r;

  // memory port control
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = ring_addr(slot_r, chpos_r);
    mem_we      = 1'b0;
    mem_wr_addr = idx_r;
    mem_wr_data = new_val;
    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wr_addr = clr_r;
        mem_wr_data = '0;
      end
      ST_IDLE: begin
        mem_rd_en = accept;
      end
      ST_RMW: begin
        mem_we = 1'b1;
      end
      ST_SCAN: begin
        mem_rd_en   = (scan_r < SCNT_W'(HISTORY_SLOTS));
        mem_rd_addr = ring_addr(scan_r[SLOT_W-1:0], ch_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data_r <= ring_mem[mem_rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == ADDR_W'(RING_SIZE - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_RMW;
      end
      ST_RMW: begin
        state_nxt = end_r ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_r == SCNT_W'(HISTORY_SLOTS)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      fpc_r       <= FPC_RESET;
      slot_r      <= '0;
      chpos_r     <= '0;
      frame_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) fpc_r <= cfg_wr_data;
      if (state_r == ST_CLEAR) clr_r <= clr_r + ADDR_W'(1);

      if (accept) begin
        if (ch_last) begin
          chpos_r <= '0;
          if (chunk_end) begin
            frame_r <= '0;
            slot_r  <= (slot_r == SLOT_W'(HISTORY_SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);
          end else begin
            frame_r <= frame_r + FRAME_W'(1);
          end
        end else begin
          chpos_r <= chpos_r + CH_W'(1);
        end
      end

      if (state_r == ST_RMW) begin
        scan_r <= '0;
      end else if (state_r == ST_SCAN) begin
        scan_r <= scan_r + SCNT_W'(1);
      end

      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r   <= sample_mag(in_sample);
      ch_r    <= chpos_r;
      idx_r   <= ring_addr(slot_r, chpos_r);
      end_r   <= chunk_end;
      first_r <= (frame_r == '0);
    end
    if (state_r == ST_RMW) begin
      best_r <= '0;
    end else if (state_r == ST_SCAN && scan_r != '0) begin
      best_r <= best_nxt;
    end
    if (state_r == ST_EMIT && out_free) begin
      out_channel_r <= CHAN_OUT_W'(ch_r);
      out_level_r   <= LEVEL_W'(best_r);
      out_last_r    <= (ch_r == CH_W'(NUM_CHANNELS - 1));
    end
  end

endmodule

FILE: bench/peak_report_checker.sv
`timescale 1ns / 1ps

module peak_report_checker
  import wpm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [CHAN_OUT_W-1:0]         out_channel,
  input  logic [LEVEL_W-1:0]            out_level,
  input  logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic [FPC_W-1:0]              cfg_wr_data,
  output int                            mismatches,
  output int                            outstanding,
  output int                            samples_seen,
  output int                            reports_seen
);

  typedef struct packed {
    logic [CHAN_OUT_W-1:0] channel;
    logic [LEVEL_W-1:0]    level;
    logic                  last;
  } level_report_t;

  level_report_t expected_reports[$];

  // per-slot, per-channel running peaks
  logic [LEVEL_W-1:0] slot_peak [HISTORY_SLOTS][NUM_CHANNELS];
  logic [FPC_W-1:0]   chunk_frames = FPC_RESET;
  int slot_idx = 0;
  int chan_idx = 0;
  int frames_done = 0;
  int errors = 0;
  int accepted = 0;
  int checked = 0;

  function automatic logic [LEVEL_W-1:0] magnitude_of(input logic [SAMPLE_BITS-1:0] s);
    int v;
    v = int'($signed(s));
    if (v < 0) v = -v;
    if (v > 2 ** (SAMPLE_BITS - 1) - 1) v = 2 ** (SAMPLE_BITS - 1) - 1;
    return LEVEL_W'(v);
  endfunction

  task automatic predict_levels(input logic [SAMPLE_BITS-1:0] s);
    logic [LEVEL_W-1:0] mag;
    logic [LEVEL_W-1:0] best;
    level_report_t rep;
    int span;
    bit closes;
    mag = magnitude_of(s);
    // zero acts as one frame, anything past the maximum acts as the maximum
    if (chunk_frames == '0) span = 1;
    else if (chunk_frames > FPC_MAX) span = int'(FPC_MAX);
    else span = int'(chunk_frames);
    closes = (frames_done + 1 >= span);
    if (frames_done == 0 || mag > slot_peak[slot_idx][chan_idx])
      slot_peak[slot_idx][chan_idx] = mag;
    if (closes) begin
      best = '0;
      for (int k = 0; k < HISTORY_SLOTS; k++)
        if (slot_peak[k][chan_idx] > best) best = slot_peak[k][chan_idx];
      rep.channel = CHAN_OUT_W'(chan_idx);
      rep.level   = best;
      rep.last    = (chan_idx == NUM_CHANNELS - 1);
      expected_reports.push_back(rep);
    end
    if (chan_idx == NUM_CHANNELS - 1) begin
      chan_idx = 0;
      if (closes) begin
        frames_done = 0;
        slot_idx = (slot_idx + 1) % HISTORY_SLOTS;
      end else begin
        frames_done++;
      end
    end else begin
      chan_idx++;
    end
  endtask

  always @(posedge clk) begin
    level_report_t want;
    if (!rst_n) begin
      for (int k = 0; k < HISTORY_SLOTS; k++)
        for (int c = 0; c < NUM_CHANNELS; c++)
          slot_peak[k][c] = '0;
      chunk_frames = FPC_RESET;
      slot_idx = 0;
      chan_idx = 0;
      frames_done = 0;
      expected_reports.delete();
    end else begin
      if (cfg_wr_en) chunk_frames = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected report: ch=%0d level=%0d last=%0b",
                     out_channel, out_level, out_last);
        end else begin
          want = expected_reports.pop_front();
          checked++;
          if (out_channel !== want.channel || out_level !== want.level ||
              out_last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display(
                "report %0d: expected ch=%0d level=%0d last=%0b, got ch=%0d level=%0d last=%0b",
                checked, want.channel, want.level, want.last,
                out_channel, out_level, out_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        accepted++;
        predict_levels(in_sample);
      end
    end
    mismatches   <= errors;
    outstanding  <= expected_reports.size();
    samples_seen <= accepted;
    reports_seen <= checked;
  end

endmodule

FILE: bench/windowed_peak_level_meter_core_test.sv
`timescale 1ns / 1ps

module windowed_peak_level_meter_core_test;
  import wpm_pkg::*;

  localparam int SETTLE_CYCLES = 4 * HISTORY_SLOTS + 16;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [SAMPLE_BITS-1:0] CORNER_SAMPLES [12] = '{
    16'h0000, 16'h7fff, 16'h8000, 16'h8001, 16'hffff, 16'h0001,
    16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 16'h0064, 16'hff9c
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [CHAN_OUT_W-1:0]         out_channel;
  logic [LEVEL_W-1:0]            out_level;
  logic                          out_last;
  logic                          cfg_wr_en = 1'b0;
  logic [FPC_W-1:0]              cfg_wr_data = FPC_RESET;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_shift = 0;
  int mismatches;
  int outstanding;
  int samples_seen;
  int reports_seen;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  windowed_peak_level_meter_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_channel (out_channel),
    .out_level   (out_level),
    .out_last    (out_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  peak_report_checker levels_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .out_level    (out_level),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .samples_seen (samples_seen),
    .reports_seen (reports_seen)
  );

  // result side: random stall, plus long hold-offs on request
  always @(posedge clk) begin
    if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic set_traffic(input int send_idle, input int recv_stall);
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
  endtask

  task automatic write_chunk_frames(input logic [FPC_W-1:0] frames);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= frames;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // stop offering, let every report arrive, then give the block time to settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    logic signed [SAMPLE_BITS-1:0] s;
    s = SAMPLE_BITS'($urandom);
    case ($urandom_range(0, 11))
      0: s = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      1: s = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      2: s = '1;
      3: s = '0;
      default: s = s >>> quiet_shift;
    endcase
    return s;
  endfunction

  // loudness changes every few frames so older slots dominate the window at times
  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) quiet_shift = $urandom_range(0, 1) ? 0 : $urandom_range(1, 14);
      send_sample(random_sample());
    end
  endtask

  initial begin
    logic [FPC_W-1:0] frames;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_chunk_frames(FPC_W'(1));
    foreach (CORNER_SAMPLES[i]) send_sample(CORNER_SAMPLES[i]);
    wait_drained();

    write_chunk_frames(FPC_W'(0));
    send_sample(16'h8000);
    send_sample(16'h0007);
    send_sample(16'h0000);
    send_sample(16'h7fff);
    wait_drained();

    write_chunk_frames(FPC_W'(4));
    repeat (6) send_sample(random_sample());
    wait_drained();
    // chunk already past the new length: the next frame closes it
    write_chunk_frames(FPC_W'(2));
    repeat (2) send_sample(random_sample());
    wait_drained();

    // long chunk lengths: a partial chunk, closed early by a later, shorter rewrite
    write_chunk_frames(FPC_MAX);
    send_random(60);
    wait_drained();
    write_chunk_frames('1);
    send_random(60);
    wait_drained();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: set_traffic(0, 0);
        1: set_traffic(77, 0);
        2: set_traffic(0, 77);
        default: set_traffic(7, 7);
      endcase
      case ($urandom_range(0, 9))
        0: frames = '0;
        1: frames = FPC_W'($urandom_range(7, 24));
        default: frames = FPC_W'($urandom_range(1, 6));
      endcase
      if (ph == 0) frames = FPC_W'(5);
      if (ph == 4) frames = FPC_W'(1);
      write_chunk_frames(frames);
      // long output hold while input keeps coming: the block must back up
      if (ph == 4) hold_requests++;
      send_random(22);
      if (ph == 9) wait_drained();
      send_random(22);
      wait_drained();
    end

    $display("summary: %0d samples, %0d channel reports checked, chunk lengths 0 to 8191",
             samples_seen, reports_seen);
    $display("summary: idle/stall mixes incl. a %0d-cycle output hold and mid-chunk rewrites",
             HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
